[rtl/core/ebb_pkg.sv]
package ebb_pkg;

  localparam int unsigned SAMPLE_W      = 16;
  localparam int unsigned NUM_CH        = 3;
  localparam int unsigned RADIUS_W      = 4;
  localparam int unsigned RADIUS_RESET  = 2;
  localparam int unsigned MAX_RADIUS_DEF = 15;
  localparam int unsigned MAX_LINE_DEF  = 4096;
  localparam int unsigned OUT_DEPTH_DEF = 8;

  // Channel order: red, green, blue
  typedef logic [NUM_CH-1:0][SAMPLE_W-1:0] pix_t;

  typedef struct packed {
    pix_t mean;
    logic last;
  } res_t;

endpackage

[rtl/core/ebb_ram.sv]
module ebb_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/ebb_div.sv]
// Rounded divide of three channel sums by a small count.
// Reciprocal multiply, then one correction step.
module ebb_div #(
  parameter int unsigned SUM_W = 21,
  parameter int unsigned CNT_W = 5
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   launch_i,
  input  logic [ebb_pkg::NUM_CH-1:0][SUM_W-1:0]  sum_i,
  input  logic [CNT_W-1:0]                       cnt_i,
  input  logic                                   last_i,
  output logic                                   res_valid_o,
  output ebb_pkg::res_t                          res_o
);

  localparam int unsigned NW    = SUM_W + 1;
  localparam int unsigned PW    = 2 * NW + 1;
  localparam int unsigned RW    = NW + CNT_W;
  localparam int unsigned NCnt  = 2 ** CNT_W;

  logic [NW:0] rcp [NCnt];

  for (genvar g = 0; g < NCnt; g++) begin : g_rcp
    localparam logic [NW:0] Rcp = (NW+1)'((64'd1 << NW) / ((g == 0) ? 1 : g));
    assign rcp[g] = Rcp;
  end

  logic                                  v0_q, v1_q, v2_q, v3_q;
  logic [ebb_pkg::NUM_CH-1:0][SUM_W-1:0] sum0_q;
  logic [CNT_W-1:0]                      cnt0_q, cnt1_q, cnt2_q;
  logic                                  last0_q, last1_q, last2_q, last3_q;
  logic [ebb_pkg::NUM_CH-1:0][NW-1:0]    n1_d, n1_q, n2_q;
  logic [NW:0]                           m1_d, m1_q;
  logic [ebb_pkg::NUM_CH-1:0][NW-1:0]    q0_d, q0_q;
  logic [PW-1:0]                         prod [ebb_pkg::NUM_CH];
  logic [RW-1:0]                         rem  [ebb_pkg::NUM_CH];
  ebb_pkg::pix_t                         q_d, q_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v0_q <= launch_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Stage 1: add half the count for rounding, look up the reciprocal
  always_comb begin
    for (int ch = 0; ch < ebb_pkg::NUM_CH; ch++) begin
      n1_d[ch] = NW'(sum0_q[ch]) + NW'(cnt0_q >> 1);
    end
    m1_d = rcp[cnt0_q];
  end

  // Stage 2: estimate quotient, low by at most one
  always_comb begin
    for (int ch = 0; ch < ebb_pkg::NUM_CH; ch++) begin
      prod[ch] = PW'(n1_q[ch]) * PW'(m1_q);
      q0_d[ch] = prod[ch][2*NW-1:NW];
    end
  end

  // Stage 3: correct with the remainder
  always_comb begin
    for (int ch = 0; ch < ebb_pkg::NUM_CH; ch++) begin
      rem[ch] = RW'(n2_q[ch]) - RW'(q0_q[ch]) * RW'(cnt2_q);
      q_d[ch] = (rem[ch] >= RW'(cnt2_q)) ? ebb_pkg::SAMPLE_W'(q0_q[ch] + NW'(1))
                                         : ebb_pkg::SAMPLE_W'(q0_q[ch]);
    end
  end

  always_ff @(posedge clk_i) begin
    sum0_q  <= sum_i;
    cnt0_q  <= cnt_i;
    last0_q <= last_i;
    n1_q    <= n1_d;
    m1_q    <= m1_d;
    cnt1_q  <= cnt0_q;
    last1_q <= last0_q;
    q0_q    <= q0_d;
    n2_q    <= n1_q;
    cnt2_q  <= cnt1_q;
    last2_q <= last1_q;
    q_q     <= q_d;
    last3_q <= last2_q;
  end

  assign res_valid_o = v3_q;
  assign res_o.mean  = q_q;
  assign res_o.last  = last3_q;

endmodule

[rtl/core/ebb_outq.sv]
module ebb_outq #(
  parameter int unsigned DEPTH = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ebb_pkg::res_t push_data_i,
  input  logic          pop_i,
  output logic          valid_o,
  output ebb_pkg::res_t data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);

  ebb_pkg::res_t   entry_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_d  = push_i ? ((wr_q == PtrLast) ? '0 : wr_q + PtrW'(1)) : wr_q;
    rd_d  = pop_i  ? ((rd_q == PtrLast) ? '0 : rd_q + PtrW'(1)) : rd_q;
    cnt_d = cnt_q;
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= push_data_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = entry_q[rd_q];

endmodule

[rtl/core/edge_normalized_box_blur_line_core.sv]
// Edge-normalized box blur over one line of RGB pixels (unsigned 8.8).
// Each beat out is the per-channel mean of the in-line samples within
// radius of one position, the window clipped at both line ends and divided
// by its true sample count, rounded to nearest with ties up. Results lag
// the input by radius positions; the end_of_line beat (or the beat at
// position MAX_LINE-1) flushes the remaining positions, the final one
// carrying line_done. Rate: a line streams at one sample per cycle while
// the result queue has room. A last-in-line beat then holds the input
// while its min(position, radius)+1 flush results are issued, one per
// cycle while the queue has room. Results pass a four-stage reciprocal
// divider and an OUT_DEPTH-entry result queue; the input stalls whenever
// queued plus in-flight results fill that queue. Samples live in a
// 2*MAX_RADIUS+2 entry ring RAM, read in the cycle before the running-sum
// subtract that needs them. No clearing pass after reset. The radius port
// is taken only between flushes; a write mid-line drops the line in
// progress.
module edge_normalized_box_blur_line_core #(
  parameter int unsigned MAX_RADIUS = ebb_pkg::MAX_RADIUS_DEF,
  parameter int unsigned MAX_LINE   = ebb_pkg::MAX_LINE_DEF,
  parameter int unsigned OUT_DEPTH  = ebb_pkg::OUT_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // sample input
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [ebb_pkg::SAMPLE_W-1:0]    sample_red_i,
  input  logic [ebb_pkg::SAMPLE_W-1:0]    sample_green_i,
  input  logic [ebb_pkg::SAMPLE_W-1:0]    sample_blue_i,
  input  logic                            end_of_line_i,
  // mean output
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [ebb_pkg::SAMPLE_W-1:0]    mean_red_o,
  output logic [ebb_pkg::SAMPLE_W-1:0]    mean_green_o,
  output logic [ebb_pkg::SAMPLE_W-1:0]    mean_blue_o,
  output logic                            line_done_o,
  // radius write
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ebb_pkg::RADIUS_W-1:0]    cfg_radius_i
);

  localparam int unsigned RingDepth = 2 * MAX_RADIUS + 2;
  localparam int unsigned SlotW     = $clog2(RingDepth);
  localparam int unsigned PosW      = $clog2(MAX_LINE);
  localparam int unsigned CntW      = $clog2(2 * MAX_RADIUS + 2);
  localparam int unsigned SumW      = ebb_pkg::SAMPLE_W + $clog2(2 * MAX_RADIUS + 1);
  localparam int unsigned RamW      = ebb_pkg::NUM_CH * ebb_pkg::SAMPLE_W;
  localparam int unsigned CreditW   = $clog2(OUT_DEPTH + 1);
  localparam int unsigned RadCodeMax = 2 ** ebb_pkg::RADIUS_W - 1;
  localparam int unsigned RadLimit  = (MAX_RADIUS < RadCodeMax) ? MAX_RADIUS : RadCodeMax;
  localparam int unsigned RadReset  =
    (ebb_pkg::RADIUS_RESET < RadLimit) ? ebb_pkg::RADIUS_RESET : RadLimit;

  localparam logic [PosW-1:0]    LastPos  = PosW'(MAX_LINE - 1);
  localparam logic [SlotW-1:0]   SlotLast = SlotW'(RingDepth - 1);
  localparam logic [CreditW-1:0] CreditFull = CreditW'(OUT_DEPTH);

  // Sequencer states
  localparam logic ST_IDLE  = 1'b0;  // take samples and radius writes
  localparam logic ST_FLUSH = 1'b1;  // drain the tail of the line

  // Step a ring slot back by off positions, modulo the ring depth.
  function automatic logic [SlotW-1:0] slot_back(input logic [SlotW-1:0] s,
                                                 input logic [SlotW:0]   off);
    logic [SlotW:0] tmp;
    tmp = {1'b0, s} + (SlotW+1)'(RingDepth) - off;
    if (tmp >= (SlotW+1)'(RingDepth)) begin
      tmp = tmp - (SlotW+1)'(RingDepth);
    end
    return tmp[SlotW-1:0];
  endfunction

  logic                         state_q, state_d;
  logic [ebb_pkg::RADIUS_W-1:0] radius_q, radius_d;
  logic [PosW-1:0]              pos_q, pos_d;        // next sample position
  logic [SlotW-1:0]             slot_q, slot_d;      // ring slot of pos_q
  logic [ebb_pkg::NUM_CH-1:0][SumW-1:0] sums_q, sums_d;
  logic                         pend_q, pend_d;      // ring read data owed to the sums
  logic [PosW-1:0]              c_q, c_d;            // flush position
  logic [PosW-1:0]              endp_q, endp_d;      // last position of the line
  logic [SlotW-1:0]             fslot_q, fslot_d;    // ring slot of c_q - radius
  logic [CreditW-1:0]           credit_q, credit_d;  // results in divider plus queue

  ebb_pkg::pix_t                         samp;
  ebb_pkg::pix_t                         ring_rd;
  logic [RamW-1:0]                       ram_rdata;
  logic                                  ram_we, ram_re;
  logic [SlotW-1:0]                      ram_raddr;
  logic [ebb_pkg::NUM_CH-1:0][SumW-1:0]  sums_eff, sum_plus, l_sum;
  logic                                  launch, l_last;
  logic [CntW-1:0]                       l_cnt, ord_cnt, fl_cnt;
  logic [PosW-1:0]                       r_pos, r2_pos, min_2r, fl_span;
  logic [SlotW:0]                        r_sl, r2_sl, min_r_sl;
  logic                                  in_acc, out_acc, cfg_acc, credit_ok;
  logic                                  is_last, p_ge_r, p_ge_2r, c_ge_r, fl_last;
  logic                                  div_valid, q_valid;
  ebb_pkg::res_t                         div_res, q_data;

  assign samp    = {sample_blue_i, sample_green_i, sample_red_i};
  assign ring_rd = ram_rdata;

  assign credit_ok   = (credit_q != CreditFull);
  assign in_stall_o  = (state_q != ST_IDLE) || !credit_ok || cfg_valid_i;
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign out_acc     = q_valid && !out_stall_i;

  assign r_pos    = PosW'(radius_q);
  assign r2_pos   = r_pos << 1;
  assign r_sl     = (SlotW+1)'(radius_q);
  assign r2_sl    = r_sl << 1;
  assign is_last  = end_of_line_i || (pos_q == LastPos);
  assign p_ge_r   = (pos_q >= r_pos);
  assign p_ge_2r  = (pos_q >= r2_pos);
  assign min_r_sl = p_ge_r ? r_sl : (SlotW+1)'(pos_q);

  // Window count of an ordinary result: min(p, 2r) + 1
  assign min_2r  = p_ge_2r ? r2_pos : pos_q;
  assign ord_cnt = CntW'(min_2r) + CntW'(1);

  // Window count of a flush result: endp - max(0, c - r) + 1
  assign c_ge_r  = (c_q >= r_pos);
  assign fl_span = c_ge_r ? (endp_q - (c_q - r_pos)) : endp_q;
  assign fl_cnt  = CntW'(fl_span) + CntW'(1);
  assign fl_last = (c_q == endp_q);

  // Settle the subtract owed from last cycle's ring read, then add the new sample.
  always_comb begin
    for (int ch = 0; ch < ebb_pkg::NUM_CH; ch++) begin
      sums_eff[ch] = sums_q[ch] - (pend_q ? SumW'(ring_rd[ch]) : SumW'(0));
      sum_plus[ch] = sums_eff[ch] + SumW'(samp[ch]);
    end
  end

  always_comb begin
    state_d   = state_q;
    radius_d  = radius_q;
    pos_d     = pos_q;
    slot_d    = slot_q;
    sums_d    = sums_eff;
    pend_d    = 1'b0;
    c_d       = c_q;
    endp_d    = endp_q;
    fslot_d   = fslot_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    launch    = 1'b0;
    l_sum     = sums_eff;
    l_cnt     = ord_cnt;
    l_last    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (cfg_acc) begin
          // New radius: drop the line in progress.
          radius_d = (cfg_radius_i > ebb_pkg::RADIUS_W'(RadLimit))
                   ? ebb_pkg::RADIUS_W'(RadLimit) : cfg_radius_i;
          sums_d   = '0;
          pos_d    = '0;
          slot_d   = '0;
        end else if (in_acc) begin
          ram_we = 1'b1;
          if (is_last) begin
            // Hold the sum with the new sample, then drain from max(0, p-r).
            sums_d  = sum_plus;
            endp_d  = pos_q;
            c_d     = p_ge_r ? (pos_q - r_pos) : '0;
            fslot_d = slot_back(slot_q, r_sl + min_r_sl);
            state_d = ST_FLUSH;
          end else begin
            launch = p_ge_r;
            l_sum  = sum_plus;
            l_cnt  = ord_cnt;
            // A zero radius window holds only the current sample.
            sums_d = (radius_q == '0) ? '0 : sum_plus;
            if (p_ge_2r && (radius_q != '0)) begin
              ram_re    = 1'b1;
              ram_raddr = slot_back(slot_q, r2_sl);
              pend_d    = 1'b1;
            end
            pos_d  = pos_q + PosW'(1);
            slot_d = (slot_q == SlotLast) ? '0 : slot_q + SlotW'(1);
          end
        end
      end
      ST_FLUSH: begin
        if (credit_ok) begin
          launch = 1'b1;
          l_sum  = sums_eff;
          l_cnt  = fl_cnt;
          l_last = fl_last;
          if (c_ge_r) begin
            ram_re    = 1'b1;
            ram_raddr = fslot_q;
            pend_d    = 1'b1;
          end
          fslot_d = (fslot_q == SlotLast) ? '0 : fslot_q + SlotW'(1);
          c_d     = c_q + PosW'(1);
          if (fl_last) begin
            state_d = ST_IDLE;
            sums_d  = '0;
            pend_d  = 1'b0;
            pos_d   = '0;
            slot_d  = '0;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    case ({launch, out_acc})
      2'b10:   credit_d = credit_q + CreditW'(1);
      2'b01:   credit_d = credit_q - CreditW'(1);
      default: credit_d = credit_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      radius_q <= ebb_pkg::RADIUS_W'(RadReset);
      pos_q    <= '0;
      slot_q   <= '0;
      sums_q   <= '0;
      pend_q   <= 1'b0;
      c_q      <= '0;
      endp_q   <= '0;
      fslot_q  <= '0;
      credit_q <= '0;
    end else begin
      state_q  <= state_d;
      radius_q <= radius_d;
      pos_q    <= pos_d;
      slot_q   <= slot_d;
      sums_q   <= sums_d;
      pend_q   <= pend_d;
      c_q      <= c_d;
      endp_q   <= endp_d;
      fslot_q  <= fslot_d;
      credit_q <= credit_d;
    end
  end

  ebb_ram #(
    .WIDTH (RamW),
    .DEPTH (RingDepth)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (samp),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ebb_div #(
    .SUM_W (SumW),
    .CNT_W (CntW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .launch_i    (launch),
    .sum_i       (l_sum),
    .cnt_i       (l_cnt),
    .last_i      (l_last),
    .res_valid_o (div_valid),
    .res_o       (div_res)
  );

  ebb_outq #(
    .DEPTH (OUT_DEPTH)
  ) u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (div_valid),
    .push_data_i (div_res),
    .pop_i       (out_acc),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  assign out_valid_o  = q_valid;
  assign mean_red_o   = q_data.mean[0];
  assign mean_green_o = q_data.mean[1];
  assign mean_blue_o  = q_data.mean[2];
  assign line_done_o  = q_data.last;

endmodule

[rtl/core/ebb_chk.sv]
module ebb_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic [ebb_pkg::SAMPLE_W-1:0] sample_red_i,
  input logic [ebb_pkg::SAMPLE_W-1:0] sample_green_i,
  input logic [ebb_pkg::SAMPLE_W-1:0] sample_blue_i,
  input logic                         end_of_line_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [ebb_pkg::SAMPLE_W-1:0] mean_red_o,
  input logic [ebb_pkg::SAMPLE_W-1:0] mean_green_o,
  input logic [ebb_pkg::SAMPLE_W-1:0] mean_blue_o,
  input logic                         line_done_o,
  input logic                         cfg_valid_i,
  input logic                         cfg_ready_o,
  input logic [ebb_pkg::RADIUS_W-1:0] cfg_radius_i
);

  // Hold a stalled result beat.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(mean_red_o) && $stable(mean_green_o)
                                   && $stable(mean_blue_o) && $stable(line_done_o))
    else $error("stalled result beat changed");

  // A radius write never shares a cycle with a sample beat.
  a_cfg_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |-> in_stall_o)
    else $error("sample beat taken with a radius write");

  // The end of a line starts a flush: input and radius port are closed in the next cycle.
  a_flush_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && end_of_line_i |=> in_stall_o && !cfg_ready_o)
    else $error("no flush after end of line");

endmodule

bind edge_normalized_box_blur_line_core ebb_chk u_ebb_chk (.*);
